// ===== sv/kbt_pkg.sv =====
// ----------------------------------------------------------------------------
// kbt_pkg
// Shared sizes, codes, controller/datapath handshake structs and helpers
// for the keyed binding table.
// ----------------------------------------------------------------------------
package kbt_pkg;

	localparam int ENTRIES     = 16;
	localparam int KEY_WIDTH   = 32;
	localparam int MAX_RESULTS = 16;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	typedef logic [KEY_WIDTH-1:0] key_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	typedef enum logic [2:0] {
		CMD_BIND   = 3'd0,
		CMD_UNBIND = 3'd1,
		CMD_LOOKUP = 3'd2,
		CMD_TOUCH  = 3'd3,
		CMD_EXPIRE = 3'd4,
		CMD_COUNT  = 3'd5,
		CMD_LIST   = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DUP       = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic start;    // latch command word, clear scan state
		logic scan;     // examine one slot, advance index
		logic act;      // apply update, load single result or arm list
		logic emit;     // load listed entry at current index
		logic advance;  // step list index
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_end;  // index on the last slot
		logic list_go;   // list with at least one entry
		logic slot_hit;  // slot at index is active
		logic more;      // loaded result is not the final one
	} dp_stat_t;

	// input key (32b) into stored key width
	function automatic key_t to_key(input logic [31:0] k);
		logic [63:0] w;
		w = {32'b0, k};
		return w[KEY_WIDTH-1:0];
	endfunction

	// stored key back onto a 32b output field
	function automatic logic [31:0] from_key(input key_t k);
		logic [63:0] w;
		w = 64'(k);
		return w[31:0];
	endfunction

	// counts saturate at 31 on the 5b result field
	function automatic logic [4:0] sat5(input cnt_t c);
		logic [7:0] w;
		w = 8'(c);
		return (w > 8'd31) ? 5'd31 : w[4:0];
	endfunction

endpackage

// ===== sv/kbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// kbt_ctrl
// Command sequencer: accept, slot scan, update, result handoff and the
// per-entry loop of a list.
// ----------------------------------------------------------------------------
module kbt_ctrl
	import kbt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output dp_cmd_t  dcmd,
	input  dp_stat_t dstat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_ACT,
		S_SEEK,
		S_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		dcmd         = '0;
		dcmd.start   = (state_q == S_IDLE) && in_valid;
		dcmd.scan    = (state_q == S_SCAN);
		dcmd.act     = (state_q == S_ACT);
		dcmd.emit    = (state_q == S_SEEK) && dstat.slot_hit;
		dcmd.advance = ((state_q == S_SEEK) && !dstat.slot_hit) ||
			((state_q == S_RESP) && out_ready && dstat.more);
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (dstat.scan_end)
						state_q <= S_ACT;
				end
				S_ACT: begin
					if (dstat.list_go) begin
						state_q <= S_SEEK;
					end else begin
						state_q     <= S_RESP;
						out_valid_q <= 1'b1;
					end
				end
				S_SEEK: begin
					if (dstat.slot_hit) begin
						state_q     <= S_RESP;
						out_valid_q <= 1'b1;
					end
				end
				S_RESP: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= dstat.more ? S_SEEK : S_IDLE;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== sv/kbt_dp.sv =====
// ----------------------------------------------------------------------------
// kbt_dp
// Slot storage, one-slot-per-cycle scan unit (match, free slot, counts,
// expiry) and the result word register.
// ----------------------------------------------------------------------------
module kbt_dp
	import kbt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     dcmd,
	output dp_stat_t    dstat,
	input  logic [2:0]  cmd,
	input  logic [31:0] channel_key,
	input  logic [31:0] thread_key,
	input  logic [63:0] bind_agent,
	input  logic [31:0] idle_timeout,
	input  logic [31:0] now,
	output logic [1:0]  status,
	output logic [63:0] out_agent,
	output logic [4:0]  result_count,
	output logic [31:0] out_channel,
	output logic [31:0] out_thread,
	output logic [31:0] out_created,
	output logic [31:0] out_active_time,
	output logic [31:0] out_timeout,
	output logic        entry_present,
	output logic        last
);

	// slot storage
	logic [ENTRIES-1:0] valid_q;
	key_t               chan_mem [ENTRIES];
	key_t               thr_mem  [ENTRIES];
	logic [63:0]        agent_mem[ENTRIES];
	logic [31:0]        crt_mem  [ENTRIES];
	logic [31:0]        la_mem   [ENTRIES];
	logic [31:0]        tmo_mem  [ENTRIES];

	// latched command word
	cmd_t        cmd_q;
	key_t        ch_q;
	key_t        th_q;
	logic [63:0] agent_q;
	logic [31:0] tmo_q;
	logic [31:0] now_q;

	// scan state
	idx_t        idx_q;
	cnt_t        cnt_q;
	logic        found_q;
	idx_t        hit_idx_q;
	logic [63:0] hit_agent_q;
	logic        free_found_q;
	idx_t        free_idx_q;
	cnt_t        n_q;
	cnt_t        k_q;

	// result word
	status_t     status_q;
	logic [63:0] out_agent_q;
	logic [4:0]  count_q;
	logic [31:0] out_ch_q;
	logic [31:0] out_th_q;
	logic [31:0] out_crt_q;
	logic [31:0] out_la_q;
	logic [31:0] out_tmo_q;
	logic        present_q;
	logic        last_q;

	// per-slot evaluation at the scan index
	logic        cur_valid;
	logic        cur_match;
	logic [31:0] cur_idle;
	logic        cur_expire;
	logic        cur_count;

	always_comb begin
		cur_valid  = valid_q[idx_q];
		cur_match  = cur_valid && (chan_mem[idx_q] == ch_q) && (thr_mem[idx_q] == th_q);
		cur_idle   = (now_q >= la_mem[idx_q]) ? (now_q - la_mem[idx_q]) : 32'd0;
		cur_expire = (cmd_q == CMD_EXPIRE) && cur_valid && (tmo_mem[idx_q] != 32'd0) &&
			(cur_idle >= tmo_mem[idx_q]);
		cur_count  = (cmd_q == CMD_EXPIRE) ? cur_expire : cur_valid;
	end

	// update strobes
	logic bind_wr, touch_wr, unbind_clr, list_go;

	assign bind_wr    = dcmd.act && (cmd_q == CMD_BIND) && !found_q && free_found_q;
	assign touch_wr   = dcmd.act && (cmd_q == CMD_TOUCH) && found_q;
	assign unbind_clr = dcmd.act && (cmd_q == CMD_UNBIND) && found_q;
	assign list_go    = (cmd_q == CMD_LIST) && (cnt_q != '0);

	// single-word result of a non-list command
	status_t res_status;

	always_comb begin
		case (cmd_q)
			CMD_BIND: begin
				if (found_q)
					res_status = ST_DUP;
				else if (!free_found_q)
					res_status = ST_FULL;
				else
					res_status = ST_OK;
			end
			CMD_UNBIND, CMD_LOOKUP, CMD_TOUCH:
				res_status = found_q ? ST_OK : ST_NOT_FOUND;
			CMD_EXPIRE, CMD_COUNT, CMD_LIST:
				res_status = ST_OK;
			default:
				res_status = ST_NOT_FOUND;
		endcase
	end

	// valid bits: reset clear, set on bind, cleared by unbind and expiry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (dcmd.scan && cur_expire)
				valid_q[idx_q] <= 1'b0;
			if (bind_wr)
				valid_q[free_idx_q] <= 1'b1;
			if (unbind_clr)
				valid_q[hit_idx_q] <= 1'b0;
		end
	end

	// entry fields: bind writes the whole entry, touch writes last-active
	always_ff @(posedge clk) begin
		if (bind_wr) begin
			chan_mem[free_idx_q]  <= ch_q;
			thr_mem[free_idx_q]   <= th_q;
			agent_mem[free_idx_q] <= agent_q;
			crt_mem[free_idx_q]   <= now_q;
			tmo_mem[free_idx_q]   <= tmo_q;
		end
		if (bind_wr)
			la_mem[free_idx_q] <= now_q;
		else if (touch_wr)
			la_mem[hit_idx_q] <= now_q;
	end

	// command word latch
	always_ff @(posedge clk) begin
		if (dcmd.start) begin
			cmd_q   <= cmd_t'(cmd);
			ch_q    <= to_key(channel_key);
			th_q    <= to_key(thread_key);
			agent_q <= bind_agent;
			tmo_q   <= idle_timeout;
			now_q   <= now;
		end
	end

	// scan index, match / free tracking, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			cnt_q        <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			k_q          <= '0;
			n_q          <= '0;
		end else begin
			if (dcmd.start) begin
				idx_q        <= '0;
				cnt_q        <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else if (dcmd.scan) begin
				idx_q <= idx_q + 1'b1;
				if (cur_count)
					cnt_q <= cnt_q + 1'b1;
				if (cur_match && !found_q)
					found_q <= 1'b1;
				if (!cur_valid && !free_found_q)
					free_found_q <= 1'b1;
			end else if (dcmd.act) begin
				// list restarts from slot 0
				idx_q <= '0;
				k_q   <= '0;
				n_q   <= (8'(cnt_q) > 8'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : cnt_q;
			end else if (dcmd.emit) begin
				k_q <= k_q + 1'b1;
			end else if (dcmd.advance) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// captured slot of first match and first free slot
	always_ff @(posedge clk) begin
		if (dcmd.scan && cur_match && !found_q) begin
			hit_idx_q   <= idx_q;
			hit_agent_q <= agent_mem[idx_q];
		end
		if (dcmd.scan && !cur_valid && !free_found_q)
			free_idx_q <= idx_q;
	end

	// result word register
	always_ff @(posedge clk) begin
		if (dcmd.act) begin
			status_q    <= res_status;
			out_agent_q <= ((cmd_q == CMD_LOOKUP) && found_q) ? hit_agent_q : 64'd0;
			count_q     <= ((cmd_q == CMD_EXPIRE) || (cmd_q == CMD_COUNT)) ?
				sat5(cnt_q) : 5'd0;
			out_ch_q    <= 32'd0;
			out_th_q    <= 32'd0;
			out_crt_q   <= 32'd0;
			out_la_q    <= 32'd0;
			out_tmo_q   <= 32'd0;
			present_q   <= 1'b0;
			last_q      <= 1'b1;
		end else if (dcmd.emit) begin
			status_q    <= ST_OK;
			out_agent_q <= agent_mem[idx_q];
			count_q     <= sat5(n_q);
			out_ch_q    <= from_key(chan_mem[idx_q]);
			out_th_q    <= from_key(thr_mem[idx_q]);
			out_crt_q   <= crt_mem[idx_q];
			out_la_q    <= la_mem[idx_q];
			out_tmo_q   <= tmo_mem[idx_q];
			present_q   <= 1'b1;
			last_q      <= (({1'b0, k_q} + 1'b1) == {1'b0, n_q});
		end
	end

	assign dstat.scan_end = (idx_q == IDX_W'(ENTRIES - 1));
	assign dstat.list_go  = list_go;
	assign dstat.slot_hit = cur_valid;
	assign dstat.more     = !last_q;

	assign status          = status_q;
	assign out_agent       = out_agent_q;
	assign result_count    = count_q;
	assign out_channel     = out_ch_q;
	assign out_thread      = out_th_q;
	assign out_created     = out_crt_q;
	assign out_active_time = out_la_q;
	assign out_timeout     = out_tmo_q;
	assign entry_present   = present_q;
	assign last            = last_q;

endmodule

// ===== sv/keyed_binding_table_with_idle_expiry_core.sv =====
// ----------------------------------------------------------------------------
// keyed_binding_table_with_idle_expiry_core
// Table of (channel, thread) -> agent bindings with per-entry idle expiry.
//
//   channel  dir  handshake             word
//   -------  ---  --------------------  -------------------------------------
//   in       in   in_valid / in_ready   cmd, keys, bind_agent, idle_timeout, now
//   out      out  out_valid / out_ready status, agent, count, entry fields,
//                                       entry_present, last
//
// Every command scans all ENTRIES slots, one per cycle, through a single
// compare/subtract unit. List then walks the slots again from slot 0,
// stepping over empty slots and loading one output word per active slot.
// Reset clears all valid bits at once; no clearing pass.
// A stalled output word holds the sequencer; no new command is taken until
// the final word of the current one is accepted.
// ----------------------------------------------------------------------------
module keyed_binding_table_with_idle_expiry_core
	import kbt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [31:0] channel_key,
	input  logic [31:0] thread_key,
	input  logic [63:0] bind_agent,
	input  logic [31:0] idle_timeout,
	input  logic [31:0] now,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [63:0] out_agent,
	output logic [4:0]  result_count,
	output logic [31:0] out_channel,
	output logic [31:0] out_thread,
	output logic [31:0] out_created,
	output logic [31:0] out_active_time,
	output logic [31:0] out_timeout,
	output logic        entry_present,
	output logic        last
);

	dp_cmd_t  dcmd;
	dp_stat_t dstat;

	// sequencer
	kbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dcmd      (dcmd),
		.dstat     (dstat)
	);

	// storage, scan unit and result register
	kbt_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.dcmd            (dcmd),
		.dstat           (dstat),
		.cmd             (cmd),
		.channel_key     (channel_key),
		.thread_key      (thread_key),
		.bind_agent      (bind_agent),
		.idle_timeout    (idle_timeout),
		.now             (now),
		.status          (status),
		.out_agent       (out_agent),
		.result_count    (result_count),
		.out_channel     (out_channel),
		.out_thread      (out_thread),
		.out_created     (out_created),
		.out_active_time (out_active_time),
		.out_timeout     (out_timeout),
		.entry_present   (entry_present),
		.last            (last)
	);

endmodule

// ===== verif/binding_table_checker.sv =====
// ----------------------------------------------------------------------------
// binding_table_checker
// Watches both channels of the keyed binding table. It keeps its own copy of
// the slot table and works out the reply words for every accepted command.
// Each accepted output word is compared field by field against the oldest
// pending reply.
// ----------------------------------------------------------------------------
module binding_table_checker
	import kbt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [31:0] channel_key,
	input  logic [31:0] thread_key,
	input  logic [63:0] bind_agent,
	input  logic [31:0] idle_timeout,
	input  logic [31:0] now,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [63:0] out_agent,
	input  logic [4:0]  result_count,
	input  logic [31:0] out_channel,
	input  logic [31:0] out_thread,
	input  logic [31:0] out_created,
	input  logic [31:0] out_active_time,
	input  logic [31:0] out_timeout,
	input  logic        entry_present,
	input  logic        last,
	output int          mismatches,
	output int          replies_due,
	output int          words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 40;

	typedef struct {
		logic [1:0]  status;
		logic [63:0] agent;
		logic [4:0]  count;
		logic [31:0] channel;
		logic [31:0] thread;
		logic [31:0] created;
		logic [31:0] active_time;
		logic [31:0] timeout;
		logic        present;
		logic        last;
	} reply_t;

	// reply words still owed by the block, oldest first
	reply_t pending_replies[$];

	// shadow copy of the slot table
	bit          bound[ENTRIES];
	key_t        bound_channel[ENTRIES];
	key_t        bound_thread[ENTRIES];
	logic [63:0] bound_agent[ENTRIES];
	logic [31:0] bound_created[ENTRIES];
	logic [31:0] bound_active[ENTRIES];
	logic [31:0] bound_timeout[ENTRIES];

	function automatic int find_pair(key_t ch, key_t th);
		for (int i = 0; i < ENTRIES; i++)
			if (bound[i] && bound_channel[i] == ch && bound_thread[i] == th)
				return i;
		return -1;
	endfunction

	function automatic logic [4:0] clip5(int n);
		return (n > 31) ? 5'd31 : n[4:0];
	endfunction

	// apply one command to the shadow table and queue the words it yields
	task automatic table_replies(input logic [2:0] op, input logic [31:0] ch_in,
		input logic [31:0] th_in, input logic [63:0] agent, input logic [31:0] tmo,
		input logic [31:0] t_now);
		reply_t      r;
		key_t        ch;
		key_t        th;
		int          slot;
		int          n;
		int          k;
		logic [31:0] idle;

		r = '{default: '0};
		r.last = 1'b1;
		ch = key_t'(ch_in);
		th = key_t'(th_in);
		slot = find_pair(ch, th);
		n = 0;
		case (op)
		CMD_BIND: begin
			if (slot >= 0) begin
				r.status = ST_DUP;
			end else begin
				// lowest free slot
				for (int i = ENTRIES - 1; i >= 0; i--)
					if (!bound[i])
						slot = i;
				if (slot < 0) begin
					r.status = ST_FULL;
				end else begin
					bound[slot]         = 1'b1;
					bound_channel[slot] = ch;
					bound_thread[slot]  = th;
					bound_agent[slot]   = agent;
					bound_created[slot] = t_now;
					bound_active[slot]  = t_now;
					bound_timeout[slot] = tmo;
				end
			end
		end
		CMD_UNBIND: begin
			if (slot < 0) r.status = ST_NOT_FOUND;
			else bound[slot] = 1'b0;
		end
		CMD_LOOKUP: begin
			if (slot < 0) r.status = ST_NOT_FOUND;
			else r.agent = bound_agent[slot];
		end
		CMD_TOUCH: begin
			if (slot < 0) r.status = ST_NOT_FOUND;
			else bound_active[slot] = t_now;
		end
		CMD_EXPIRE: begin
			// time running backwards counts as zero idle time
			for (int i = 0; i < ENTRIES; i++) begin
				if (bound[i] && bound_timeout[i] != 32'd0) begin
					idle = (t_now >= bound_active[i]) ? t_now - bound_active[i] : 32'd0;
					if (idle >= bound_timeout[i]) begin
						bound[i] = 1'b0;
						n++;
					end
				end
			end
			r.count = clip5(n);
		end
		CMD_COUNT: begin
			for (int i = 0; i < ENTRIES; i++)
				if (bound[i])
					n++;
			r.count = clip5(n);
		end
		CMD_LIST: begin
			for (int i = 0; i < ENTRIES; i++)
				if (bound[i])
					n++;
			if (n > MAX_RESULTS)
				n = MAX_RESULTS;
			k = 0;
			for (int i = 0; i < ENTRIES && k < n; i++) begin
				if (bound[i]) begin
					r.agent       = bound_agent[i];
					r.count       = clip5(n);
					r.channel     = 32'(bound_channel[i]);
					r.thread      = 32'(bound_thread[i]);
					r.created     = bound_created[i];
					r.active_time = bound_active[i];
					r.timeout     = bound_timeout[i];
					r.present     = 1'b1;
					r.last        = (k + 1 == n);
					pending_replies.push_back(r);
					k++;
				end
			end
		end
		default: begin
			r.status = ST_NOT_FOUND;
		end
		endcase
		// a list queues its own words; an empty list still gives one
		if (op != CMD_LIST || n == 0)
			pending_replies.push_back(r);
	endtask

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
		end
	endfunction

	// output side first: a word leaving now belongs to an older command
	always @(posedge clk) begin : watch
		reply_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				words_checked++;
				if (pending_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$error("output word with no reply pending");
				end else begin
					want = pending_replies.pop_front();
					check_field("status", 64'(want.status), 64'(status));
					check_field("out_agent", want.agent, out_agent);
					check_field("result_count", 64'(want.count), 64'(result_count));
					check_field("out_channel", 64'(want.channel), 64'(out_channel));
					check_field("out_thread", 64'(want.thread), 64'(out_thread));
					check_field("out_created", 64'(want.created), 64'(out_created));
					check_field("out_active_time", 64'(want.active_time),
						64'(out_active_time));
					check_field("out_timeout", 64'(want.timeout), 64'(out_timeout));
					check_field("entry_present", 64'(want.present), 64'(entry_present));
					check_field("last", 64'(want.last), 64'(last));
				end
			end
			if (in_valid && in_ready)
				table_replies(cmd, channel_key, thread_key, bind_agent, idle_timeout, now);
			replies_due = pending_replies.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives commands into the keyed binding table with random gaps and output
// stalls: a directed opening (empty table, extreme keys and times, duplicate,
// absent pairs, full table, expiry on the boundary and with time running
// backwards), then random command streams over a small key pool.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import kbt_pkg::*;

	localparam int          CLK_PERIOD    = 20;
	localparam int          RESET_CYCLES  = 8;
	localparam int          RANDOM_ITEMS  = 248;
	localparam int          DRAIN_CYCLES  = 60;
	localparam int          CYCLE_LIMIT   = 1000000;
	localparam int          POOL_SIZE     = 5;
	localparam logic [2:0]  CMD_UNDEFINED = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  cmd;
	logic [31:0] channel_key;
	logic [31:0] thread_key;
	logic [63:0] bind_agent;
	logic [31:0] idle_timeout;
	logic [31:0] now;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [63:0] out_agent;
	logic [4:0]  result_count;
	logic [31:0] out_channel;
	logic [31:0] out_thread;
	logic [31:0] out_created;
	logic [31:0] out_active_time;
	logic [31:0] out_timeout;
	logic        entry_present;
	logic        last;
	int          mismatches;
	int          replies_due;
	int          words_checked;

	// stimulus controls
	bit          tx_calm;
	bit          rx_calm;
	int          rx_hold;
	int          cycles;
	int          issued[8];
	logic [31:0] clock_s;
	logic [31:0] chan_pool[POOL_SIZE];
	logic [31:0] thr_pool[POOL_SIZE];

	always #(CLK_PERIOD / 2) clk = ~clk;

	keyed_binding_table_with_idle_expiry_core u_top (.*);

	binding_table_checker u_checker (.*);

	// one command word: optional gap, then hold until accepted
	task automatic send_word(input logic [2:0] op, input logic [31:0] ch,
		input logic [31:0] th, input logic [63:0] agent, input logic [31:0] tmo,
		input logic [31:0] t_now);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 19);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= op;
		channel_key  <= ch;
		thread_key   <= th;
		bind_agent   <= agent;
		idle_timeout <= tmo;
		now          <= t_now;
		do @(posedge clk); while (!in_ready);
		issued[op]++;
	endtask

	function automatic logic [31:0] pick_key(logic [31:0] pool[POOL_SIZE]);
		return ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL_SIZE - 1)]
			: $urandom;
	endfunction

	// mostly forward steps, some backwards times, some jumps anywhere
	function automatic logic [31:0] next_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			clock_s += $urandom_range(0, 12);
			return clock_s;
		end
		if (r < 90)
			return clock_s - $urandom_range(1, 30);
		clock_s = $urandom;
		return clock_s;
	endfunction

	function automatic logic [31:0] pick_timeout();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return 32'd0;
		if (r < 80) return $urandom_range(1, 40);
		if (r < 95) return $urandom_range(41, 1000);
		return $urandom;
	endfunction

	function automatic logic [2:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 34) return CMD_BIND;
		if (r < 46) return CMD_UNBIND;
		if (r < 58) return CMD_LOOKUP;
		if (r < 68) return CMD_TOUCH;
		if (r < 78) return CMD_EXPIRE;
		if (r < 85) return CMD_COUNT;
		if (r < 96) return CMD_LIST;
		return CMD_UNDEFINED;
	endfunction

	// receiver: per-word stall, plus a long hold-off on request
	initial begin : rx
		int stall;
		stall = 0;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold--;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
			end
			@(posedge clk);
			if (out_valid && out_ready)
				stall = rx_calm ? 0 : $urandom_range(0, 19);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stim
		logic [2:0] op;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		cmd          = CMD_BIND;
		channel_key  = 32'd0;
		thread_key   = 32'd0;
		bind_agent   = 64'd0;
		idle_timeout = 32'd0;
		now          = 32'd0;
		chan_pool[0] = 32'd0;
		chan_pool[1] = 32'hFFFF_FFFF;
		thr_pool[0]  = 32'd0;
		thr_pool[1]  = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++) begin
			chan_pool[i] = $urandom;
			thr_pool[i]  = $urandom;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table
		send_word(CMD_LIST, 32'd0, 32'd0, 64'd0, 32'd0, 32'd0);
		send_word(CMD_COUNT, 32'd0, 32'd0, 64'd0, 32'd0, 32'd0);
		send_word(CMD_EXPIRE, 32'd0, 32'd0, 64'd0, 32'd0, 32'd0);
		// all-zero entry never expires; all-ones entry at the top of time
		send_word(CMD_BIND, 32'd0, 32'd0, 64'd0, 32'd0, 32'd0);
		send_word(CMD_BIND, '1, '1, '1, '1, '1);
		send_word(CMD_BIND, 32'd0, 32'd0, 64'h1234, 32'd5, 32'd7);
		send_word(CMD_LOOKUP, '1, '1, 64'd0, 32'd0, 32'd0);
		send_word(CMD_LOOKUP, 32'd1, 32'd0, 64'd0, 32'd0, 32'd0);
		send_word(CMD_TOUCH, 32'd0, 32'd1, 64'd0, 32'd0, 32'd3);
		send_word(CMD_TOUCH, '1, '1, 64'd0, 32'd0, 32'd5);
		send_word(CMD_UNBIND, 32'd9, 32'd9, 64'd0, 32'd0, 32'd0);
		send_word(CMD_UNDEFINED, 32'd0, 32'd0, 64'd0, 32'd0, 32'd0);
		// fill the table, then overflow it
		for (int i = 0; i < ENTRIES - 2; i++)
			send_word(CMD_BIND, 32'h100 + i, $urandom, {$urandom, $urandom}, 32'd10, 32'd100);
		send_word(CMD_BIND, 32'h200, 32'd0, 64'd1, 32'd1, 32'd100);
		send_word(CMD_LIST, 32'd0, 32'd0, 64'd0, 32'd0, 32'd0);
		// backwards time frees nothing; idle equal to timeout frees
		send_word(CMD_EXPIRE, 32'd0, 32'd0, 64'd0, 32'd0, 32'd50);
		send_word(CMD_EXPIRE, 32'd0, 32'd0, 64'd0, 32'd0, 32'd110);
		send_word(CMD_UNBIND, 32'd0, 32'd0, 64'd0, 32'd0, 32'd0);
		send_word(CMD_COUNT, 32'd0, 32'd0, 64'd0, 32'd0, 32'd0);

		// random streams over the key pool
		clock_s = 32'd200;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			tx_calm = (n >= 40 && n < 70);
			rx_calm = (n >= 40 && n < 70);
			if (n == 110)
				rx_hold = 400;
			if (n == 200) begin
				@(negedge clk);
				in_valid <= 1'b0;
				wait (replies_due == 0);
			end
			op = pick_op();
			send_word(op, pick_key(chan_pool), pick_key(thr_pool), {$urandom, $urandom},
				pick_timeout(), next_time());
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait (replies_due == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d binds, %0d unbinds, %0d lookups, %0d touches, %0d expires,",
			issued[CMD_BIND], issued[CMD_UNBIND], issued[CMD_LOOKUP], issued[CMD_TOUCH],
			issued[CMD_EXPIRE]);
		$display("%0d counts, %0d lists, %0d undefined; %0d reply words compared",
			issued[CMD_COUNT], issued[CMD_LIST], issued[CMD_UNDEFINED], words_checked);
		if (mismatches == 0 && replies_due == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
